// ----- rtl/core/trajectory_command_handler_top_defines.svh -----
// assertion macros for the trajectory command handler
`ifndef TRAJECTORY_COMMAND_HANDLER_TOP_DEFINES_SVH
`define TRAJECTORY_COMMAND_HANDLER_TOP_DEFINES_SVH
`define TCH_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("%m: label failed");
`define TCH_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("%m: label failed");
`endif

// ----- rtl/core/tch_pkg.sv -----
// shared types, constants and functions of the trajectory command handler
package tch_pkg;
    localparam int POINT_DEPTH = 256;
    localparam int CNT_W = $clog2(POINT_DEPTH + 1);
    localparam int ADDR_W = $clog2(POINT_DEPTH);
    localparam int GAIN_N = 18;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CMD_STOP = 8'd0;
    localparam logic [7:0] CMD_BEGIN = 8'd2;
    localparam logic [7:0] CMD_LEFT = 8'd3;
    localparam logic [7:0] CMD_RIGHT = 8'd4;
    localparam logic [7:0] CMD_FINISH = 8'd5;
    localparam logic [7:0] CMD_TRACK = 8'd6;
    localparam logic [7:0] CMD_AUX = 8'd7;
    localparam logic [7:0] CMD_PULSE_L = 8'd8;
    localparam logic [7:0] CMD_PULSE_R = 8'd9;
    localparam logic [7:0] CMD_DELAY = 8'd20;
    localparam logic [7:0] CMD_GAIN = 8'd25;
    localparam logic [7:0] CMD_TCONST = 8'd27;
    localparam logic [7:0] CMD_ACK = 8'd49;
    localparam logic [7:0] CMD_PKT = 8'd51;

    localparam logic [7:0] TYPE_ACK = 8'd40;
    localparam logic [7:0] TYPE_ERR = 8'd100;
    localparam logic [7:0] FRAME_SYNC = 8'hAA;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [10:0] PULSE_MID = 11'd1500;
    localparam logic [10:0] PULSE_LOW = 11'd1180;
    localparam logic [10:0] PULSE_HIGH = 11'd1820;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_RECV = 3'd1,
        MODE_READY = 3'd2,
        MODE_TRACK = 3'd3,
        MODE_AUX = 3'd4
    } mode_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_STOP, OP_BEGIN, OP_LEFT, OP_RIGHT, OP_FINISH, OP_TRACK, OP_AUX,
        OP_PULSE_L, OP_PULSE_R, OP_DELAY, OP_GAIN, OP_TCONST, OP_ACK, OP_PKT
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] value;
        logic [31:0] position;
        logic [31:0] velocity;
    } job_t;

    typedef struct packed {
        logic        has_reply;
        logic [7:0]  reply_type;
        logic [15:0] reply_value;
        logic [31:0] reply_position;
        logic [31:0] reply_velocity;
        logic [15:0] reply_crc;
        logic [2:0]  mode_now;
        logic        drive_on;
        logic        arm_side_neg;
        logic        arm_dir;
        logic        host_acked;
        logic [15:0] packet_count;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        return c;
    endfunction
endpackage

// ----- rtl/core/tch_if.sv -----
// valid/ready channel interfaces of the trajectory command handler
interface tch_cmd_if (input logic clk);
    logic        valid;
    logic        ready;
    logic [7:0]  cmd;
    logic [15:0] arg_value;
    logic [31:0] arg_position;
    logic [31:0] arg_velocity;
    modport source (output valid, cmd, arg_value, arg_position, arg_velocity, input ready);
    modport sink (input valid, cmd, arg_value, arg_position, arg_velocity, output ready);
endinterface

interface tch_res_if (input logic clk);
    logic        valid;
    logic        ready;
    logic        has_reply;
    logic [7:0]  reply_type;
    logic [15:0] reply_value;
    logic [31:0] reply_position;
    logic [31:0] reply_velocity;
    logic [15:0] reply_crc;
    logic [2:0]  mode_now;
    logic        drive_on;
    logic        arm_side_neg;
    logic        arm_dir;
    logic        host_acked;
    logic [15:0] packet_count;
    modport source (output valid, has_reply, reply_type, reply_value, reply_position,
        reply_velocity, reply_crc, mode_now, drive_on, arm_side_neg, arm_dir, host_acked,
        packet_count, input ready);
    modport sink (input valid, has_reply, reply_type, reply_value, reply_position,
        reply_velocity, reply_crc, mode_now, drive_on, arm_side_neg, arm_dir, host_acked,
        packet_count, output ready);
endinterface

// ----- rtl/core/tch_front.sv -----
// front end: decodes command frames into jobs and queues them
module tch_front (
    input  logic          clk,
    input  logic          rst_n,
    tch_cmd_if.sink       cmd_ch,
    output tch_pkg::job_t job,
    output logic          job_valid,
    input  logic          job_ready
);
    import tch_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    job_t              queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]    fill_reg, fill_next;
    op_t               op;
    logic              push, pop;

    always_comb
    begin
        case (cmd_ch.cmd)
            CMD_STOP:    op = OP_STOP;
            CMD_BEGIN:   op = OP_BEGIN;
            CMD_LEFT:    op = OP_LEFT;
            CMD_RIGHT:   op = OP_RIGHT;
            CMD_FINISH:  op = OP_FINISH;
            CMD_TRACK:   op = OP_TRACK;
            CMD_AUX:     op = OP_AUX;
            CMD_PULSE_L: op = OP_PULSE_L;
            CMD_PULSE_R: op = OP_PULSE_R;
            CMD_DELAY:   op = OP_DELAY;
            CMD_GAIN:    op = OP_GAIN;
            CMD_TCONST:  op = OP_TCONST;
            CMD_ACK:     op = OP_ACK;
            CMD_PKT:     op = OP_PKT;
            default:     op = OP_NONE;
        endcase
    end

    assign cmd_ch.ready = (fill_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign push = cmd_ch.valid && cmd_ch.ready;
    assign job_valid = (fill_reg != '0);
    assign pop = job_valid && job_ready;
    assign job = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next = fill_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= '{op: op, value: cmd_ch.arg_value,
                position: cmd_ch.arg_position, velocity: cmd_ch.arg_velocity};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg <= fill_next;
        end
    end
endmodule

// ----- rtl/core/tch_crc.sv -----
// crc-16/ccitt-false over the twelve bytes of a reply frame
module tch_crc (
    input  logic [7:0]  rtype,
    input  logic [15:0] rvalue,
    input  logic [31:0] rposition,
    input  logic [31:0] rvelocity,
    output logic [15:0] crc
);
    import tch_pkg::*;

    logic [7:0] bytes [12];

    always_comb
    begin
        logic [15:0] c;
        bytes[0] = FRAME_SYNC;
        bytes[1] = rtype;
        bytes[2] = rvalue[7:0];
        bytes[3] = rvalue[15:8];
        for (int i = 0; i < 4; i++)
        begin
            bytes[4+i] = rposition[8*i +: 8];
            bytes[8+i] = rvelocity[8*i +: 8];
        end
        c = CRC_INIT;
        for (int i = 0; i < 12; i++)
        begin
            c = crc_byte(c, bytes[i]);
        end
        crc = c;
    end
endmodule

// ----- rtl/core/tch_back.sv -----
// back end: executes jobs, keeps controller state and registers results
module tch_back (
    input  logic          clk,
    input  logic          rst_n,
    input  tch_pkg::job_t job,
    input  logic          job_valid,
    output logic          job_ready,
    tch_res_if.source     res_ch
);
    import tch_pkg::*;

    mode_t             mode_reg, mode_next;
    logic              drive_reg, drive_next;
    logic [CNT_W-1:0]  lcnt_reg, lcnt_next;
    logic [CNT_W-1:0]  rcnt_reg, rcnt_next;
    logic              side_reg, side_next;
    logic              dir_reg, dir_next;
    logic [10:0]       pulse_l_reg, pulse_l_next;
    logic [10:0]       pulse_r_reg, pulse_r_next;
    logic [15:0]       delay_reg, delay_next;
    logic [15:0]       tconst_reg, tconst_next;
    logic [31:0]       gain_reg [GAIN_N];
    logic              ack_reg, ack_next;
    logic [15:0]       pkt_reg, pkt_next;
    logic [31:0]       left_angle_mem [POINT_DEPTH];
    logic [31:0]       left_speed_mem [POINT_DEPTH];
    logic [31:0]       right_angle_mem [POINT_DEPTH];
    logic [31:0]       right_speed_mem [POINT_DEPTH];

    logic              rep, wr_left, wr_right, gain_ok;
    logic [7:0]        rtype;
    logic [15:0]       rval;
    logic [15:0]       crc;
    logic [4:0]        gidx;
    logic              out_valid_reg;
    result_t           out_reg, res;
    logic              step;
    logic [15:0]       val_ext;

    assign job_ready = !out_valid_reg || res_ch.ready;
    assign step = job_valid && job_ready;
    assign val_ext = job.value;
    assign gain_ok = (job.value <= 16'd8);
    assign gidx = {job.value[3:0], 1'b0};

    always_comb
    begin
        mode_next = mode_reg;
        drive_next = drive_reg;
        lcnt_next = lcnt_reg;
        rcnt_next = rcnt_reg;
        side_next = side_reg;
        dir_next = dir_reg;
        pulse_l_next = pulse_l_reg;
        pulse_r_next = pulse_r_reg;
        delay_next = delay_reg;
        tconst_next = tconst_reg;
        ack_next = ack_reg;
        pkt_next = pkt_reg;
        rep = 1'b0;
        rtype = TYPE_ACK;
        rval = job.value;
        wr_left = 1'b0;
        wr_right = 1'b0;
        case (job.op)
            OP_STOP: drive_next = 1'b0;
            OP_BEGIN:
            begin
                mode_next = MODE_RECV;
                lcnt_next = '0;
                rcnt_next = '0;
                rep = 1'b1;
            end
            OP_LEFT:
            begin
                if (mode_reg == MODE_RECV)
                begin
                    rep = 1'b1;
                    if (16'(lcnt_reg) == val_ext && lcnt_reg < CNT_W'(POINT_DEPTH))
                    begin
                        wr_left = 1'b1;
                        lcnt_next = lcnt_reg + 1'b1;
                        rval = 16'(lcnt_next);
                    end
                    else
                    begin
                        mode_next = MODE_IDLE;
                        rtype = TYPE_ERR;
                    end
                end
            end
            OP_RIGHT:
            begin
                if (mode_reg == MODE_RECV)
                begin
                    rep = 1'b1;
                    if (16'(rcnt_reg) == val_ext && rcnt_reg < CNT_W'(POINT_DEPTH))
                    begin
                        wr_right = 1'b1;
                        rcnt_next = rcnt_reg + 1'b1;
                        rval = 16'(rcnt_next);
                    end
                    else
                    begin
                        mode_next = MODE_IDLE;
                        rtype = TYPE_ERR;
                        rval = 16'(rcnt_reg);
                    end
                end
            end
            OP_FINISH:
            begin
                rep = 1'b1;
                rval = 16'(lcnt_reg);
                if (mode_reg == MODE_RECV && 16'(lcnt_reg) == val_ext
                    && 16'(rcnt_reg) == val_ext)
                begin
                    mode_next = MODE_READY;
                end
                else
                begin
                    rtype = TYPE_ERR;
                end
            end
            OP_TRACK, OP_AUX:
            begin
                rep = 1'b1;
                rval = 16'(lcnt_reg);
                if (mode_reg == MODE_READY)
                begin
                    drive_next = 1'b1;
                    mode_next = (job.op == OP_TRACK) ? MODE_TRACK : MODE_AUX;
                    if (job.op == OP_AUX && (job.value inside {16'd0, 16'd1, 16'd10, 16'd11}))
                    begin
                        side_next = job.value[0];
                        dir_next = (job.value >= 16'd10);
                    end
                end
                else
                begin
                    rtype = TYPE_ERR;
                end
            end
            OP_PULSE_L: pulse_l_next = (job.value == '0) ? PULSE_LOW : PULSE_MID;
            OP_PULSE_R: pulse_r_next = (job.value == '0) ? PULSE_HIGH : PULSE_MID;
            OP_DELAY:
            begin
                delay_next = job.value;
                rep = 1'b1;
            end
            OP_GAIN: rep = 1'b1;
            OP_TCONST:
            begin
                tconst_next = job.value;
                rep = 1'b1;
            end
            OP_ACK: ack_next = 1'b1;
            OP_PKT:
            begin
                ack_next = 1'b1;
                pkt_next = pkt_reg + 16'd1;
            end
            default: ;
        endcase
    end

    tch_crc u_crc (
        .rtype(rtype),
        .rvalue(rval),
        .rposition(job.position),
        .rvelocity(job.velocity),
        .crc(crc)
    );

    always_comb
    begin
        res.has_reply = rep;
        res.reply_type = rep ? rtype : '0;
        res.reply_value = rep ? rval : '0;
        res.reply_position = rep ? job.position : '0;
        res.reply_velocity = rep ? job.velocity : '0;
        res.reply_crc = rep ? crc : '0;
        res.mode_now = mode_next;
        res.drive_on = drive_next;
        res.arm_side_neg = side_next;
        res.arm_dir = dir_next;
        res.host_acked = ack_next;
        res.packet_count = pkt_next;
    end

    always_ff @(posedge clk)
    begin
        if (step && wr_left)
        begin
            left_angle_mem[lcnt_reg[ADDR_W-1:0]] <= job.position;
            left_speed_mem[lcnt_reg[ADDR_W-1:0]] <= job.velocity;
        end
        if (step && wr_right)
        begin
            right_angle_mem[rcnt_reg[ADDR_W-1:0]] <= job.position;
            right_speed_mem[rcnt_reg[ADDR_W-1:0]] <= job.velocity;
        end
        if (step)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            drive_reg <= 1'b0;
            lcnt_reg <= '0;
            rcnt_reg <= '0;
            side_reg <= 1'b0;
            dir_reg <= 1'b0;
            pulse_l_reg <= PULSE_MID;
            pulse_r_reg <= PULSE_MID;
            delay_reg <= '0;
            tconst_reg <= '0;
            ack_reg <= 1'b0;
            pkt_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < GAIN_N; i++)
            begin
                gain_reg[i] <= '0;
            end
        end
        else
        begin
            if (step)
            begin
                mode_reg <= mode_next;
                drive_reg <= drive_next;
                lcnt_reg <= lcnt_next;
                rcnt_reg <= rcnt_next;
                side_reg <= side_next;
                dir_reg <= dir_next;
                pulse_l_reg <= pulse_l_next;
                pulse_r_reg <= pulse_r_next;
                delay_reg <= delay_next;
                tconst_reg <= tconst_next;
                ack_reg <= ack_next;
                pkt_reg <= pkt_next;
                if (job.op == OP_GAIN && gain_ok)
                begin
                    if (job.position != '0)
                    begin
                        gain_reg[gidx] <= job.position;
                    end
                    if (job.velocity != '0)
                    begin
                        gain_reg[gidx + 5'd1] <= job.velocity;
                    end
                end
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res_ch.valid = out_valid_reg;
    assign res_ch.has_reply = out_reg.has_reply;
    assign res_ch.reply_type = out_reg.reply_type;
    assign res_ch.reply_value = out_reg.reply_value;
    assign res_ch.reply_position = out_reg.reply_position;
    assign res_ch.reply_velocity = out_reg.reply_velocity;
    assign res_ch.reply_crc = out_reg.reply_crc;
    assign res_ch.mode_now = out_reg.mode_now;
    assign res_ch.drive_on = out_reg.drive_on;
    assign res_ch.arm_side_neg = out_reg.arm_side_neg;
    assign res_ch.arm_dir = out_reg.arm_dir;
    assign res_ch.host_acked = out_reg.host_acked;
    assign res_ch.packet_count = out_reg.packet_count;
endmodule

// ----- rtl/core/trajectory_command_handler_top.sv -----
// trajectory command handler top level
// cmd_in takes one decoded command frame per transaction (cmd and the
// value, position and velocity arguments); res_out gives one transaction
// per frame with the optional reply frame, its crc and the controller
// status after the command.
// a frame enters a two-entry queue after decode; the back end executes
// the queue head and registers the result, so a frame passes the queue
// entry and then the result register between cmd_in and res_out.
// throughput is one frame per cycle while res_out stays ready, set by the
// execute stage with its point store write and crc tree.
// reset clears the mode, counters, flags, gains and queue; pulse widths
// return to 1500. the point stores are not cleared.
// when res_out is stalled the result register holds, the queue fills and
// cmd_in drops ready once the queue holds two frames.
module trajectory_command_handler_top (
    input  logic      clk,
    input  logic      rst_n,
    tch_cmd_if.sink   cmd_in,
    tch_res_if.source res_out
);
    import tch_pkg::*;

    job_t job;
    logic job_valid;
    logic job_ready;

    tch_front u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_ch(cmd_in),
        .job(job),
        .job_valid(job_valid),
        .job_ready(job_ready)
    );

    tch_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .job(job),
        .job_valid(job_valid),
        .job_ready(job_ready),
        .res_ch(res_out)
    );
endmodule

// ----- rtl/core/tch_checker.sv -----
// port-level checker for the trajectory command handler, with its bind
`include "trajectory_command_handler_top_defines.svh"
module tch_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        has_reply,
    input logic [7:0]  reply_type,
    input logic [15:0] reply_crc,
    input logic [2:0]  mode_now
);
    import tch_pkg::*;

    `TCH_ASSERT_IMP(a_no_reply_zero, clk, rst_n, out_valid && !has_reply,
        reply_type == 8'd0 && reply_crc == 16'd0)
    `TCH_ASSERT_IMP(a_reply_type, clk, rst_n, out_valid && has_reply,
        reply_type == TYPE_ACK || reply_type == TYPE_ERR)
    `TCH_ASSERT_IMP(a_mode_range, clk, rst_n, out_valid, mode_now <= 3'd4)
    `TCH_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `TCH_ASSERT_NXT(a_in_full_hold, clk, rst_n,
        in_valid && !in_ready && out_valid && !out_ready, !in_ready)
endmodule

bind trajectory_command_handler_top tch_checker u_tch_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(cmd_in.valid),
    .in_ready(cmd_in.ready),
    .out_valid(res_out.valid),
    .out_ready(res_out.ready),
    .has_reply(res_out.has_reply),
    .reply_type(res_out.reply_type),
    .reply_crc(res_out.reply_crc),
    .mode_now(res_out.mode_now)
);
